/* hdl/fptw_pkg.sv */
package fptw_pkg;

    localparam int VA_W    = 48;
    localparam int BASE_W  = 52;
    localparam int ENTRY_W = 64;
    localparam int ADDR_W  = 52;
    localparam int IDX_W   = 9;
    localparam int PAGE_OFS_W = 12;

    localparam int PHYS_ADDR_BITS_DEF = 52;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAGING_ON   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAE_ON      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PSE_ON      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MODE_ON = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    localparam logic [1:0] ST_READ    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    localparam logic [1:0] SIZE_4K = 2'd0;
    localparam logic [1:0] SIZE_2M = 2'd1;
    localparam logic [1:0] SIZE_1G = 2'd2;

    localparam logic [1:0] LEVEL_PML4 = 2'd3;
    localparam logic [1:0] LEVEL_PDPT = 2'd2;
    localparam logic [1:0] LEVEL_PD   = 2'd1;
    localparam logic [1:0] LEVEL_PT   = 2'd0;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_REFUSE = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic            present;
        logic            large_page;
        logic [VA_W-1:0] va;
    } qhead_t;

    localparam int QHEAD_W = $bits(qhead_t);

endpackage

/* hdl/fptw_req_if.sv */
interface fptw_req_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [fptw_pkg::VA_W-1:0]        virtual_address;
    logic [fptw_pkg::BASE_W-1:0]      table_base;
    logic [fptw_pkg::ENTRY_W-1:0]     entry_value;

    modport source (output valid, operation, virtual_address, table_base, entry_value,
                    input ready);
    modport sink (input valid, operation, virtual_address, table_base, entry_value,
                  output ready);
endinterface

/* hdl/fptw_rsp_if.sv */
interface fptw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [fptw_pkg::ADDR_W-1:0]  address;
    logic [1:0]                   page_size;
    logic [1:0]                   fault_level;

    modport source (output valid, status, address, page_size, fault_level, input ready);
    modport sink (input valid, status, address, page_size, fault_level, output ready);
endinterface

/* hdl/fptw_front.sv */
module fptw_front #(
    parameter int PHYS_ADDR_BITS = fptw_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fptw_pkg::CFG_DATA_W-1:0]   cfg_data,
    fptw_req_if.sink                          req,
    input  logic                              q_full,
    output logic                              q_push,
    output fptw_pkg::qhead_t                  q_head,
    output logic [PHYS_ADDR_BITS-13:0]        q_page
);

    logic paging_on_reg;
    logic pae_on_reg;
    logic pse_on_reg;
    logic long_mode_on_reg;
    logic refuse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_on_reg    <= 1'b0;
            pae_on_reg       <= 1'b0;
            pse_on_reg       <= 1'b0;
            long_mode_on_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fptw_pkg::CFG_PAGING_ON:    paging_on_reg    <= cfg_data[0];
                fptw_pkg::CFG_PAE_ON:       pae_on_reg       <= cfg_data[0];
                fptw_pkg::CFG_PSE_ON:       pse_on_reg       <= cfg_data[0];
                fptw_pkg::CFG_LONG_MODE_ON: long_mode_on_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign refuse = (req.virtual_address == '0) || (req.table_base == '0) || !paging_on_reg
                    || (!pae_on_reg && pse_on_reg) || !long_mode_on_reg;

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    always_comb
    begin
        q_head.va         = req.virtual_address;
        q_head.present    = req.entry_value[fptw_pkg::PRESENT_BIT];
        q_head.large_page = req.entry_value[fptw_pkg::LARGE_BIT];
        if (req.operation == fptw_pkg::OP_ENTRY)
        begin
            q_head.kind = fptw_pkg::KIND_ENTRY;
            q_page      = req.entry_value[PHYS_ADDR_BITS-1:12];
        end
        else
        begin
            q_head.kind = refuse ? fptw_pkg::KIND_REFUSE : fptw_pkg::KIND_START;
            q_page      = req.table_base[PHYS_ADDR_BITS-1:12];
        end
    end

endmodule

/* hdl/fptw_queue.sv */
module fptw_queue #(
    parameter int DEPTH = fptw_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/fptw_back.sv */
module fptw_back #(
    parameter int PHYS_ADDR_BITS = fptw_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  fptw_pkg::qhead_t           q_head,
    input  logic [PHYS_ADDR_BITS-13:0] q_page,
    output logic                       q_pop,
    fptw_rsp_if.source                 rsp
);

    localparam int PAGE_W = PHYS_ADDR_BITS - 12;

    logic                           walk_busy_reg;
    logic                           walk_busy_next;
    logic [1:0]                     walk_level_reg;
    logic [1:0]                     walk_level_next;
    logic [fptw_pkg::VA_W-1:0]      saved_va_reg;
    logic [fptw_pkg::VA_W-1:0]      saved_va_next;

    logic                           out_valid_reg;
    logic [1:0]                     out_status_reg;
    logic [fptw_pkg::ADDR_W-1:0]    out_address_reg;
    logic [1:0]                     out_size_reg;
    logic [1:0]                     out_level_reg;

    logic                           res_valid;
    logic [1:0]                     res_status;
    logic [PHYS_ADDR_BITS-1:0]      res_address;
    logic [1:0]                     res_size;
    logic [1:0]                     res_level;

    function automatic logic [fptw_pkg::IDX_W-1:0] entry_index(
        input logic [fptw_pkg::VA_W-1:0] va,
        input logic [1:0]                level
    );
        logic [fptw_pkg::IDX_W-1:0] idx;
        case (level)
            fptw_pkg::LEVEL_PML4: idx = va[47:39];
            fptw_pkg::LEVEL_PDPT: idx = va[38:30];
            fptw_pkg::LEVEL_PD:   idx = va[29:21];
            default:              idx = va[20:12];
        endcase
        return idx;
    endfunction

    assign q_pop = q_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        walk_busy_next  = walk_busy_reg;
        walk_level_next = walk_level_reg;
        saved_va_next   = saved_va_reg;
        res_valid       = 1'b0;
        res_status      = fptw_pkg::ST_READ;
        res_address     = '0;
        res_size        = fptw_pkg::SIZE_4K;
        res_level       = fptw_pkg::LEVEL_PT;
        case (q_head.kind)
            fptw_pkg::KIND_START:
            begin
                walk_busy_next  = 1'b1;
                walk_level_next = fptw_pkg::LEVEL_PML4;
                saved_va_next   = q_head.va;
                res_valid       = 1'b1;
                res_address     = {q_page, entry_index(q_head.va, fptw_pkg::LEVEL_PML4),
                                   3'b000};
                res_level       = fptw_pkg::LEVEL_PML4;
            end
            fptw_pkg::KIND_REFUSE:
            begin
                walk_busy_next  = 1'b0;
                walk_level_next = fptw_pkg::LEVEL_PT;
                res_valid       = 1'b1;
                res_status      = fptw_pkg::ST_REFUSED;
            end
            fptw_pkg::KIND_ENTRY:
            begin
                if (walk_busy_reg)
                begin
                    res_valid = 1'b1;
                    if (!q_head.present)
                    begin
                        walk_busy_next  = 1'b0;
                        walk_level_next = fptw_pkg::LEVEL_PT;
                        res_status      = fptw_pkg::ST_ABSENT;
                        res_level       = walk_level_reg;
                    end
                    else if (walk_level_reg == fptw_pkg::LEVEL_PDPT && q_head.large_page)
                    begin
                        walk_busy_next  = 1'b0;
                        walk_level_next = fptw_pkg::LEVEL_PT;
                        res_status      = fptw_pkg::ST_DONE;
                        res_size        = fptw_pkg::SIZE_1G;
                        res_address     = {q_page[PAGE_W-1:18], saved_va_reg[29:0]};
                    end
                    else if (walk_level_reg == fptw_pkg::LEVEL_PD && q_head.large_page)
                    begin
                        walk_busy_next  = 1'b0;
                        walk_level_next = fptw_pkg::LEVEL_PT;
                        res_status      = fptw_pkg::ST_DONE;
                        res_size        = fptw_pkg::SIZE_2M;
                        res_address     = {q_page[PAGE_W-1:9], saved_va_reg[20:0]};
                    end
                    else if (walk_level_reg == fptw_pkg::LEVEL_PT)
                    begin
                        walk_busy_next  = 1'b0;
                        res_status      = fptw_pkg::ST_DONE;
                        res_address     = {q_page, saved_va_reg[11:0]};
                    end
                    else
                    begin
                        walk_level_next = walk_level_reg - 1'b1;
                        res_address     = {q_page, entry_index(saved_va_reg,
                                           walk_level_reg - 1'b1), 3'b000};
                        res_level       = walk_level_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg  <= 1'b0;
            walk_level_reg <= fptw_pkg::LEVEL_PT;
            saved_va_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                walk_busy_reg  <= walk_busy_next;
                walk_level_reg <= walk_level_next;
                saved_va_reg   <= saved_va_next;
            end
            if (q_pop && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && res_valid)
        begin
            out_status_reg  <= res_status;
            out_address_reg <= fptw_pkg::ADDR_W'(res_address);
            out_size_reg    <= res_size;
            out_level_reg   <= res_level;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.address     = out_address_reg;
    assign rsp.page_size   = out_size_reg;
    assign rsp.fault_level = out_level_reg;

endmodule

/* hdl/four_level_page_table_walker_top.sv */
// channel  dir  protocol     payload
// req      in   valid/ready  operation, virtual_address, table_base, entry_value
// rsp      out  valid/ready  status, address, page_size, fault_level
// cfg      in   write only   cfg_we, cfg_index, cfg_data
//
// one request per cycle in and one response per cycle out when rsp.ready stays high
// a response is registered: its request passes through the queue, then the output register
// a returned entry with no walk in progress is consumed and gives no response
// req.ready falls only when the front queue is full; rsp stalls back up through it
// rst_n clears the mode bits, the walk state and the queue at once; no clearing pass
module four_level_page_table_walker_top #(
    parameter int PHYS_ADDR_BITS = fptw_pkg::PHYS_ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH    = fptw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fptw_pkg::CFG_DATA_W-1:0]   cfg_data,
    fptw_req_if.sink                          req,
    fptw_rsp_if.source                        rsp
);

    localparam int PAGE_W = PHYS_ADDR_BITS - 12;
    localparam int ITEM_W = fptw_pkg::QHEAD_W + PAGE_W;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    fptw_pkg::qhead_t  push_head;
    logic [PAGE_W-1:0] push_page;
    fptw_pkg::qhead_t  pop_head;
    logic [PAGE_W-1:0] pop_page;
    logic [ITEM_W-1:0] push_item;
    logic [ITEM_W-1:0] pop_item;

    fptw_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_head    (push_head),
        .q_page    (push_page)
    );

    assign push_item = {push_head, push_page};

    fptw_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_item)
    );

    assign pop_head = pop_item[ITEM_W-1:PAGE_W];
    assign pop_page = pop_item[PAGE_W-1:0];

    fptw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (pop_head),
        .q_page  (pop_page),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
